// File: sv/crcfd_pkg.sv
// crcfd_pkg: shared types, constants and the CRC byte step for crc16_frame_decoder.
// No dependencies.
`default_nettype none

package crcfd_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = IDX_W + 1;
    localparam int MEM_AW      = IDX_W + 1;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [1:0] REG_SOF1    = 2'd0;
    localparam logic [1:0] REG_SOF2    = 2'd1;
    localparam logic [1:0] REG_VERSION = 2'd2;
    localparam logic [1:0] REG_MAXLEN  = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_CRC     = 2'd3;

    localparam logic KIND_GOOD  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [1:0]       err;
        logic [7:0]       ftype;
        logic [15:0]      seq;
        logic [LEN_W-1:0] len;
        logic             bank;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_job_req;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic       job_full;
        logic [1:0] busy;
    } t_back_stat;

    typedef struct packed {
        logic             kind;
        logic [1:0]       err;
        logic [7:0]       ftype;
        logic [15:0]      seq;
        logic [LEN_W-1:0] len;
        logic             has_payload;
        logic [IDX_W-1:0] index;
        logic [7:0]       data;
        logic             last;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/crc16_frame_decoder.sv
// crc16_frame_decoder: top level, joins the parser front end and the replay back end.
// Depends on crcfd_pkg, crcfd_front, crcfd_back.
//
// Input channel: one received byte per request on i_rx_byte, taken when push is high
// and full is low. Bytes are taken at one per cycle; full rises only when two frame
// requests already wait, or when payload arrives for a bank still being replayed.
// Result channel: the oldest result sits on the o_* ports while empty is low and is
// taken when pop is high. A good frame gives one result per payload byte (one result
// for an empty payload); a bad version, an oversized length or a CRC mismatch gives
// one error result. The last result of a run has o_last set.
// Once a frame's last byte is taken, its request passes the request queue, the registered
// payload memory read and the result queue before empty falls. With pop held high results
// leave at two per three cycles: a replay step waits while two are in flight.
// Two 64-byte payload banks let a new frame be parsed while the previous one is replayed.
// Configuration: i_cfg_we writes register i_cfg_idx (0 first marker, 1 second marker,
// 2 accepted version, 3 length limit) at once; write only while idle.
// Reset (synchronous, i_rst_n low) returns to marker hunt, empties both queues and
// restores register defaults. A stalled result holds; parsing continues until full.
`default_nettype none

module crc16_frame_decoder import crcfd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [7:0]       i_cfg_wdata,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       i_rx_byte,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  o_result_kind,
    output logic [1:0]            o_error_code,
    output logic [7:0]            o_frame_type,
    output logic [15:0]           o_sequence_res,
    output logic [LEN_W-1:0]      o_payload_length,
    output logic                  o_has_payload,
    output logic [IDX_W-1:0]      o_payload_index,
    output logic [7:0]            o_payload_byte,
    output logic                  o_last
);

    t_job_req   job;
    t_mem_wr    mem_wr;
    t_back_stat stat;
    t_result    res;

    crcfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_rx_byte   (i_rx_byte),
        .i_stat      (stat),
        .o_job       (job),
        .o_mem_wr    (mem_wr)
    );

    crcfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job),
        .i_mem_wr (mem_wr),
        .o_stat   (stat),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_res    (res)
    );

    assign o_result_kind    = res.kind;
    assign o_error_code     = res.err;
    assign o_frame_type     = res.ftype;
    assign o_sequence_res   = res.seq;
    assign o_payload_length = res.len;
    assign o_has_payload    = res.has_payload;
    assign o_payload_index  = res.index;
    assign o_payload_byte   = res.data;
    assign o_last           = res.last;

endmodule

`default_nettype wire

// File: sv/crcfd_front.sv
// crcfd_front: byte parser. Hunts for the marker, checks header and CRC,
// writes payload bytes to the back end memory and pushes frame requests. Uses crcfd_pkg.
`default_nettype none

module crcfd_front import crcfd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_back_stat i_stat,
    output t_job_req        o_job,
    output t_mem_wr         o_mem_wr
);

    localparam logic [3:0] PH_SOF1 = 4'd0;
    localparam logic [3:0] PH_SOF2 = 4'd1;
    localparam logic [3:0] PH_VER  = 4'd2;
    localparam logic [3:0] PH_TYPE = 4'd3;
    localparam logic [3:0] PH_SEQL = 4'd4;
    localparam logic [3:0] PH_SEQH = 4'd5;
    localparam logic [3:0] PH_LENL = 4'd6;
    localparam logic [3:0] PH_LENH = 4'd7;
    localparam logic [3:0] PH_DATA = 4'd8;
    localparam logic [3:0] PH_CRCL = 4'd9;
    localparam logic [3:0] PH_CRCH = 4'd10;

    localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(MAX_PAYLOAD);

    logic [7:0]       r_sof1, r_sof2, r_ver, n_sof1, n_sof2, n_ver;
    logic [6:0]       r_maxlen, n_maxlen;
    logic [3:0]       r_phase, n_phase;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_seq_lo, n_seq_lo;
    logic [15:0]      r_seq, n_seq;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic             r_wbank, n_wbank;

    logic             acc;
    logic [15:0]      crc_upd;
    logic [15:0]      len16;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] cnt_inc;

    assign o_full  = i_stat.job_full || (r_phase == PH_DATA && i_stat.busy[r_wbank]);
    assign acc     = i_push && !o_full;
    assign crc_upd = crc_byte(r_crc, i_rx_byte);
    assign len16   = {i_rx_byte, r_len_lo};
    assign limit   = ({1'b0, r_maxlen} > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : LEN_W'(r_maxlen);
    assign cnt_inc = r_cnt + LEN_W'(1);

    always_comb begin
        n_sof1   = r_sof1;
        n_sof2   = r_sof2;
        n_ver    = r_ver;
        n_maxlen = r_maxlen;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SOF1:    n_sof1   = i_cfg_wdata;
                REG_SOF2:    n_sof2   = i_cfg_wdata;
                REG_VERSION: n_ver    = i_cfg_wdata;
                REG_MAXLEN:  n_maxlen = i_cfg_wdata[6:0];
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_type   = r_type;
        n_seq_lo = r_seq_lo;
        n_seq    = r_seq;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc_lo = r_crc_lo;
        n_wbank  = r_wbank;
        o_job    = '0;
        o_mem_wr = '0;
        if (acc) begin
            unique case (r_phase)
                PH_SOF1: begin
                    if (i_rx_byte == r_sof1) n_phase = PH_SOF2;
                end
                PH_SOF2: begin
                    if (i_rx_byte == r_sof2) begin
                        n_phase = PH_VER;
                    end else if (i_rx_byte != r_sof1) begin
                        n_phase = PH_SOF1;
                    end
                end
                PH_VER: begin
                    n_crc   = crc_byte(CRC_INIT, i_rx_byte);
                    n_phase = PH_TYPE;
                    if (i_rx_byte != r_ver) begin
                        o_job.push     = 1'b1;
                        o_job.job.kind = KIND_ERROR;
                        o_job.job.err  = ERR_VERSION;
                        n_phase  = PH_SOF1;
                        n_crc    = '0;
                        n_len    = '0;
                        n_cnt    = '0;
                        n_seq_lo = '0;
                        n_len_lo = '0;
                    end
                end
                PH_TYPE: begin
                    n_crc   = crc_upd;
                    n_type  = i_rx_byte;
                    n_phase = PH_SEQL;
                end
                PH_SEQL: begin
                    n_crc    = crc_upd;
                    n_seq_lo = i_rx_byte;
                    n_phase  = PH_SEQH;
                end
                PH_SEQH: begin
                    n_crc   = crc_upd;
                    n_seq   = {i_rx_byte, r_seq_lo};
                    n_phase = PH_LENL;
                end
                PH_LENL: begin
                    n_crc    = crc_upd;
                    n_len_lo = i_rx_byte;
                    n_phase  = PH_LENH;
                end
                PH_LENH: begin
                    n_crc = crc_upd;
                    n_cnt = '0;
                    if (len16 > {{(16-LEN_W){1'b0}}, limit}) begin
                        o_job.push     = 1'b1;
                        o_job.job.kind = KIND_ERROR;
                        o_job.job.err  = ERR_LENGTH;
                        n_phase  = PH_SOF1;
                        n_crc    = '0;
                        n_len    = '0;
                        n_seq_lo = '0;
                        n_len_lo = '0;
                    end else begin
                        n_len   = len16[LEN_W-1:0];
                        n_phase = (len16 == 16'd0) ? PH_CRCL : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_crc         = crc_upd;
                    o_mem_wr.en   = 1'b1;
                    o_mem_wr.addr = {r_wbank, r_cnt[IDX_W-1:0]};
                    o_mem_wr.data = i_rx_byte;
                    n_cnt         = cnt_inc;
                    if (cnt_inc >= r_len) n_phase = PH_CRCL;
                end
                PH_CRCL: begin
                    n_crc_lo = i_rx_byte;
                    n_phase  = PH_CRCH;
                end
                PH_CRCH: begin
                    o_job.push = 1'b1;
                    if ({i_rx_byte, r_crc_lo} != r_crc) begin
                        o_job.job.kind = KIND_ERROR;
                        o_job.job.err  = ERR_CRC;
                    end else begin
                        o_job.job.kind  = KIND_GOOD;
                        o_job.job.err   = ERR_NONE;
                        o_job.job.ftype = r_type;
                        o_job.job.seq   = r_seq;
                        o_job.job.len   = r_len;
                        o_job.job.bank  = r_wbank;
                        if (r_len != '0) n_wbank = !r_wbank;
                    end
                    n_phase  = PH_SOF1;
                    n_crc    = '0;
                    n_len    = '0;
                    n_cnt    = '0;
                    n_seq_lo = '0;
                    n_len_lo = '0;
                end
                default: begin
                    n_phase  = PH_SOF1;
                    n_crc    = '0;
                    n_len    = '0;
                    n_cnt    = '0;
                    n_seq_lo = '0;
                    n_len_lo = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof1   <= 8'hAA;
            r_sof2   <= 8'h55;
            r_ver    <= 8'h01;
            r_maxlen <= 7'(MAX_PAYLOAD);
            r_phase  <= PH_SOF1;
            r_crc    <= '0;
            r_type   <= '0;
            r_seq_lo <= '0;
            r_seq    <= '0;
            r_len_lo <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_crc_lo <= '0;
            r_wbank  <= 1'b0;
        end else begin
            r_sof1   <= n_sof1;
            r_sof2   <= n_sof2;
            r_ver    <= n_ver;
            r_maxlen <= n_maxlen;
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_type   <= n_type;
            r_seq_lo <= n_seq_lo;
            r_seq    <= n_seq;
            r_len_lo <= n_len_lo;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_crc_lo <= n_crc_lo;
            r_wbank  <= n_wbank;
        end
    end

endmodule

`default_nettype wire

// File: sv/crcfd_back.sv
// crcfd_back: frame request queue, double-banked payload memory, replay sequencer
// and result queue. Uses crcfd_pkg.
`default_nettype none

module crcfd_back import crcfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job_req i_job,
    input  wire t_mem_wr  i_mem_wr,
    output t_back_stat o_stat,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_result   o_res
);

    t_job             r_jq [2];
    logic             r_jq_wp, r_jq_rp;
    logic [1:0]       r_jq_cnt;
    logic [1:0]       r_busy, n_busy;
    logic [IDX_W-1:0] r_k;
    logic [7:0]       r_mem [2**MEM_AW];
    logic [7:0]       r_mem_q;
    logic             r_rd_v;
    t_result          r_meta;
    t_result          r_of [2];
    logic             r_of_wp, r_of_rp;
    logic [1:0]       r_of_cnt;

    t_job             head;
    logic             jq_v, issue, is_last, good_data, jq_pop, of_pop;
    t_result          meta, of_wdata;

    assign head      = r_jq[r_jq_rp];
    assign jq_v      = (r_jq_cnt != 2'd0);
    assign good_data = (head.kind == KIND_GOOD) && (head.len != '0);
    assign is_last   = (head.kind == KIND_ERROR) || (head.len == '0)
                       || ({1'b0, r_k} == head.len - LEN_W'(1));
    assign issue     = jq_v && (({1'b0, r_of_cnt} + {2'b00, r_rd_v}) < 3'd2);
    assign jq_pop    = issue && is_last;
    assign of_pop    = i_pop && !o_empty;

    assign o_stat.job_full = (r_jq_cnt == 2'd2);
    assign o_stat.busy     = r_busy;

    always_comb begin
        meta             = '0;
        meta.kind        = head.kind;
        meta.err         = head.err;
        meta.ftype       = head.ftype;
        meta.seq         = head.seq;
        meta.len         = head.len;
        meta.has_payload = good_data;
        meta.index       = good_data ? r_k : '0;
        meta.last        = is_last;
    end

    always_comb begin
        of_wdata      = r_meta;
        of_wdata.data = r_meta.has_payload ? r_mem_q : 8'h00;
    end

    always_comb begin
        n_busy = r_busy;
        if (jq_pop && good_data) n_busy[head.bank] = 1'b0;
        if (i_job.push && i_job.job.kind == KIND_GOOD && i_job.job.len != '0) begin
            n_busy[i_job.job.bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        r_mem_q <= r_mem[{head.bank, r_k}];
    end

    always_ff @(posedge i_clk) begin
        if (i_job.push) r_jq[r_jq_wp] <= i_job.job;
        if (issue) r_meta <= meta;
        if (r_rd_v) r_of[r_of_wp] <= of_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jq_wp  <= 1'b0;
            r_jq_rp  <= 1'b0;
            r_jq_cnt <= '0;
            r_busy   <= '0;
            r_k      <= '0;
            r_rd_v   <= 1'b0;
            r_of_wp  <= 1'b0;
            r_of_rp  <= 1'b0;
            r_of_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_rd_v <= issue;
            if (i_job.push) r_jq_wp <= !r_jq_wp;
            if (jq_pop) r_jq_rp <= !r_jq_rp;
            r_jq_cnt <= r_jq_cnt + {1'b0, i_job.push} - {1'b0, jq_pop};
            if (issue) r_k <= is_last ? '0 : r_k + IDX_W'(1);
            if (r_rd_v) r_of_wp <= !r_of_wp;
            if (of_pop) r_of_rp <= !r_of_rp;
            r_of_cnt <= r_of_cnt + {1'b0, r_rd_v} - {1'b0, of_pop};
        end
    end

    assign o_empty = (r_of_cnt == 2'd0);
    assign o_res   = r_of[r_of_rp];

    // payload writes never land in a bank that is being replayed
    a_wr_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mem_wr.en |-> !r_busy[i_mem_wr.addr[MEM_AW-1]])
        else $error("payload write into busy bank");

    a_job_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.push |-> (r_jq_cnt != 2'd2 || jq_pop))
        else $error("frame request queue overflow");

    a_of_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_of_cnt != 2'd2 || of_pop))
        else $error("result queue overflow");

    a_replay_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && good_data) |-> r_busy[head.bank])
        else $error("replay from bank not holding a frame");

    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && is_last) |=> (r_k == '0))
        else $error("replay index not rewound after last request");

endmodule

`default_nettype wire

// File: sim/crcfd_tb_pkg.sv
`timescale 1ns / 100ps
// crcfd_tb_pkg: frame decoder predictor and result scoreboard for tb_crc16_frame_decoder.
// Depends on crcfd_pkg for result type, register and error codes.
package crcfd_tb_pkg;

    import crcfd_pkg::*;

    typedef enum logic [3:0] {
        P_SOF1, P_SOF2, P_VER, P_TYPE, P_SEQL, P_SEQH,
        P_LENL, P_LENH, P_DATA, P_CRCL, P_CRCH
    } parse_phase_e;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    class frame_scoreboard;
        logic [7:0]   sof_first;
        logic [7:0]   sof_second;
        logic [7:0]   version;
        logic [6:0]   len_limit;

        parse_phase_e phase;
        logic [15:0]  crc;
        logic [7:0]   ftype;
        logic [7:0]   seq_lo;
        logic [15:0]  seq;
        logic [7:0]   len_lo;
        logic [6:0]   held_len;
        logic [6:0]   byte_count;
        logic [7:0]   crc_lo;
        logic [7:0]   payload [MAX_PAYLOAD];

        t_result      pending_results [$];
        int unsigned  bytes_taken;
        int unsigned  results_checked;
        int unsigned  good_frames;
        int unsigned  mismatches;
        int unsigned  error_reports [4];

        function new();
            sof_first  = 8'hAA;
            sof_second = 8'h55;
            version    = 8'h01;
            len_limit  = 7'd64;
            ftype      = '0;
            seq        = '0;
            crc_lo     = '0;
            resync();
        endfunction

        function void resync();
            phase      = P_SOF1;
            crc        = '0;
            held_len   = '0;
            byte_count = '0;
            seq_lo     = '0;
            len_lo     = '0;
        endfunction

        function logic [6:0] eff_limit();
            return (len_limit > MAX_PAYLOAD) ? 7'(MAX_PAYLOAD) : len_limit;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function bit in_frame();
            return phase != P_SOF1;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [7:0] val);
            case (idx)
                REG_SOF1:    sof_first  = val;
                REG_SOF2:    sof_second = val;
                REG_VERSION: version    = val;
                REG_MAXLEN:  len_limit  = val[6:0];
                default: ;
            endcase
        endfunction

        function void report_error(input logic [1:0] code);
            t_result r;
            r      = '0;
            r.kind = KIND_ERROR;
            r.err  = code;
            r.last = 1'b1;
            pending_results.push_back(r);
            error_reports[code]++;
            resync();
        endfunction

        function void release_frame();
            t_result r;
            int      n;
            int      cnt;
            n   = (held_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(held_len);
            cnt = (n == 0) ? 1 : n;
            for (int k = 0; k < cnt; k++) begin
                r       = '0;
                r.kind  = KIND_GOOD;
                r.err   = ERR_NONE;
                r.ftype = ftype;
                r.seq   = seq;
                r.len   = held_len;
                if (n != 0) begin
                    r.has_payload = 1'b1;
                    r.index       = k[IDX_W-1:0];
                    r.data        = payload[k];
                end
                r.last = (k + 1 == cnt);
                pending_results.push_back(r);
            end
            good_frames++;
            resync();
        endfunction

        function void take_byte(input logic [7:0] b);
            logic [15:0] word;
            bytes_taken++;
            case (phase)
                P_SOF1: begin
                    if (b == sof_first) begin
                        phase = P_SOF2;
                    end
                end
                P_SOF2: begin
                    if (b == sof_second) begin
                        phase = P_VER;
                    end else if (b != sof_first) begin
                        phase = P_SOF1;
                    end
                end
                P_VER: begin
                    crc = crc_update(CRC_INIT, b);
                    if (b != version) begin
                        report_error(ERR_VERSION);
                    end else begin
                        phase = P_TYPE;
                    end
                end
                P_TYPE: begin
                    crc   = crc_update(crc, b);
                    ftype = b;
                    phase = P_SEQL;
                end
                P_SEQL: begin
                    crc    = crc_update(crc, b);
                    seq_lo = b;
                    phase  = P_SEQH;
                end
                P_SEQH: begin
                    crc   = crc_update(crc, b);
                    seq   = {b, seq_lo};
                    phase = P_LENL;
                end
                P_LENL: begin
                    crc    = crc_update(crc, b);
                    len_lo = b;
                    phase  = P_LENH;
                end
                P_LENH: begin
                    word = {b, len_lo};
                    crc  = crc_update(crc, b);
                    if (word > 16'(eff_limit())) begin
                        report_error(ERR_LENGTH);
                    end else begin
                        held_len   = word[6:0];
                        byte_count = '0;
                        phase      = (word == 16'd0) ? P_CRCL : P_DATA;
                    end
                end
                P_DATA: begin
                    crc = crc_update(crc, b);
                    if (byte_count < MAX_PAYLOAD) begin
                        payload[byte_count[IDX_W-1:0]] = b;
                    end
                    byte_count = byte_count + 7'd1;
                    if (byte_count >= held_len) begin
                        phase = P_CRCL;
                    end
                end
                P_CRCL: begin
                    crc_lo = b;
                    phase  = P_CRCH;
                end
                P_CRCH: begin
                    word = {b, crc_lo};
                    if (word != crc) begin
                        report_error(ERR_CRC);
                    end else begin
                        release_frame();
                    end
                end
                default: resync();
            endcase
        endfunction

        function void check_field(input string name, input logic [15:0] e,
                                  input logic [15:0] a);
            if (a !== e) begin
                mismatches++;
                if (mismatches <= 40) begin
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
                end
            end
        endfunction

        function void match_result(input t_result got);
            t_result e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 40) begin
                    $display("%0t: unexpected result, expected none, actual kind=%0d err=%0d",
                             $time, got.kind, got.err);
                end
                return;
            end
            e = pending_results.pop_front();
            results_checked++;
            check_field("result_kind", 16'(e.kind), 16'(got.kind));
            check_field("error_code", 16'(e.err), 16'(got.err));
            check_field("frame_type", 16'(e.ftype), 16'(got.ftype));
            check_field("sequence_res", e.seq, got.seq);
            check_field("payload_length", 16'(e.len), 16'(got.len));
            check_field("has_payload", 16'(e.has_payload), 16'(got.has_payload));
            check_field("payload_index", 16'(e.index), 16'(got.index));
            check_field("payload_byte", 16'(e.data), 16'(got.data));
            check_field("last", 16'(e.last), 16'(got.last));
        endfunction
    endclass

endpackage

// File: sim/tb_crc16_frame_decoder.sv
`timescale 1ns / 100ps
// tb_crc16_frame_decoder: drives framed byte streams into crc16_frame_decoder under
// several register settings and checks every result. Depends on crcfd_pkg, crcfd_tb_pkg.
module tb_crc16_frame_decoder;

    import crcfd_pkg::*;
    import crcfd_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int POP_FREE    = 0;
    localparam int POP_RANDOM  = 1;
    localparam int POP_SLOW    = 2;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [1:0]       i_cfg_idx   = REG_SOF1;
    logic [7:0]       i_cfg_wdata = 8'h00;
    logic             push        = 1'b0;
    logic             full;
    logic [7:0]       i_rx_byte   = 8'h00;
    logic             empty;
    logic             pop         = 1'b0;
    logic             o_result_kind;
    logic [1:0]       o_error_code;
    logic [7:0]       o_frame_type;
    logic [15:0]      o_sequence_res;
    logic [LEN_W-1:0] o_payload_length;
    logic             o_has_payload;
    logic [IDX_W-1:0] o_payload_index;
    logic [7:0]       o_payload_byte;
    logic             o_last;

    frame_scoreboard  board = new();
    int               cycle_count = 0;
    int               burst_left  = 0;
    bit               bursty      = 1'b0;
    bit               hold_req    = 1'b0;
    int unsigned      full_waits  = 0;

    crc16_frame_decoder DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_result_kind    (o_result_kind),
        .o_error_code     (o_error_code),
        .o_frame_type     (o_frame_type),
        .o_sequence_res   (o_sequence_res),
        .o_payload_length (o_payload_length),
        .o_has_payload    (o_has_payload),
        .o_payload_index  (o_payload_index),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: check on accept, then pick next pop
    initial begin
        t_result got;
        int      mode;
        int      mode_left;
        int      hold_left;
        mode      = POP_FREE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.kind        = o_result_kind;
                got.err         = o_error_code;
                got.ftype       = o_frame_type;
                got.seq         = o_sequence_res;
                got.len         = o_payload_length;
                got.has_payload = o_has_payload;
                got.index       = o_payload_index;
                got.data        = o_payload_byte;
                got.last        = o_last;
                board.match_result(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(POP_FREE, POP_SLOW);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    POP_FREE:   pop <= 1'b1;
                    POP_RANDOM: pop <= 1'($urandom_range(0, 1));
                    default:    pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (bursty && $urandom_range(0, 1)) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) begin
            full_waits++;
            @(posedge i_clk);
        end
        board.take_byte(b);
    endtask

    // stops where the decoder would stop: after a bad version or an oversized length
    task automatic send_frame(input int reps, input logic [7:0] ver, input logic [7:0] ftype,
                              input logic [15:0] seq, input logic [15:0] len16,
                              input bit corrupt);
        logic [7:0]  bytes [$];
        logic [15:0] crc;
        int          first;
        repeat (reps) bytes.push_back(board.sof_first);
        bytes.push_back(board.sof_first);
        bytes.push_back(board.sof_second);
        first = bytes.size();
        bytes.push_back(ver);
        if (ver == board.version) begin
            bytes.push_back(ftype);
            bytes.push_back(seq[7:0]);
            bytes.push_back(seq[15:8]);
            bytes.push_back(len16[7:0]);
            bytes.push_back(len16[15:8]);
            if (len16 <= 16'(board.eff_limit())) begin
                repeat (len16) bytes.push_back(8'($urandom));
                crc = CRC_INIT;
                for (int i = first; i < bytes.size(); i++) begin
                    crc = crc_update(crc, bytes[i]);
                end
                if (corrupt) begin
                    crc = crc ^ (16'd1 << $urandom_range(0, 15));
                end
                bytes.push_back(crc[7:0]);
                bytes.push_back(crc[15:8]);
            end
        end
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    function automatic logic [15:0] pick_len(input int lim);
        if ($urandom_range(0, 6) == 0) begin
            return 16'($urandom_range(0, lim));
        end
        return 16'($urandom_range(0, (lim < 6) ? lim : 6));
    endfunction

    task automatic random_request();
        int          pick;
        int          lim;
        int          reps;
        logic [15:0] len16;
        pick = $urandom_range(0, 99);
        lim  = board.eff_limit();
        reps = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : 0;
        if (board.sof_first == board.sof_second) begin
            reps = 0;
        end
        if (pick < 58) begin
            send_frame(reps, board.version, 8'($urandom), 16'($urandom), pick_len(lim), 1'b0);
        end else if (pick < 68) begin
            send_frame(reps, board.version, 8'($urandom), 16'($urandom), pick_len(lim), 1'b1);
        end else if (pick < 76) begin
            send_frame(0, board.version ^ 8'($urandom_range(1, 255)), 8'h00, 16'h0000,
                       16'h0000, 1'b0);
        end else if (pick < 84) begin
            if ($urandom_range(0, 1)) begin
                len16 = 16'(lim + $urandom_range(1, 8));
            end else begin
                len16 = {8'($urandom_range(1, 255)), 8'($urandom)};
            end
            send_frame(0, board.version, 8'($urandom), 16'($urandom), len16, 1'b0);
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
            // truncated header, the next bytes land inside it
            send_byte(board.sof_first);
            send_byte(board.sof_second);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
        end
    endtask

    task automatic random_phase(input int n_bytes);
        int unsigned start;
        start = board.bytes_taken;
        while (board.bytes_taken - start < n_bytes) random_request();
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic flush_parser();
        while (board.in_frame()) send_byte(~board.sof_first);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [7:0] sof1, input logic [7:0] sof2,
                                  input logic [7:0] ver, input logic [7:0] maxlen);
        flush_parser();
        pause_until_drained();
        cfg_write(REG_SOF1, sof1);
        cfg_write(REG_SOF2, sof2);
        cfg_write(REG_VERSION, ver);
        cfg_write(REG_MAXLEN, maxlen);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        bursty = ($urandom_range(0, 3) != 0);
    endtask

    // three payload frames while results are held: both banks fill, the third stalls
    task automatic overload();
        bit keep;
        keep     = bursty;
        bursty   = 1'b0;
        hold_req = 1'b1;
        repeat (3) begin
            send_frame(0, board.version, 8'($urandom), 16'($urandom),
                       16'($urandom_range(3, 6)), 1'b0);
        end
        bursty = keep;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: noise, empty frame behind a repeated marker, bad version,
        // length one past the limit
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(1, 8'h01, 8'hFF, 16'hFF00, 16'h0000, 1'b0);
        send_frame(0, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0);
        send_frame(0, 8'h01, 8'h00, 16'h0000, 16'h0041, 1'b0);

        bursty = 1'b1;
        random_phase(8);
        overload();
        pause_until_drained();

        apply_settings(8'h00, 8'hFF, 8'hFF, 8'h00);
        random_phase(8);
        apply_settings(8'hFF, 8'h00, 8'h00, 8'hC8);
        random_phase(8);
        apply_settings(8'h7E, 8'h7E, 8'($urandom), 8'h80 | 8'($urandom_range(1, 16)));
        random_phase(8);
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom_range(1, 64)));
        random_phase(8);

        pause_until_drained();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d bytes over five register settings; %0d results checked, %0d good frames.",
                 board.bytes_taken, board.results_checked, board.good_frames);
        $display("Error reports version/length/crc: %0d/%0d/%0d; input held by full %0d cycles.",
                 board.error_reports[ERR_VERSION], board.error_reports[ERR_LENGTH],
                 board.error_reports[ERR_CRC], full_waits);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
